// ===== sv/smr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smr_pkg
// Shared types, codes, sizes and exp tables of the softmax regression engine.
// ----------------------------------------------------------------------------
package smr_pkg;

	localparam int MAX_CLASSES_D  = 8;
	localparam int MAX_FEATURES_D = 4096;
	localparam int SAMPLE_DEPTH_D = 256;

	localparam int QUEUE_DEPTH = 4;

	// input item kinds
	localparam logic [1:0] KIND_ELEM = 2'd0;
	localparam logic [1:0] KIND_WR   = 2'd1;
	localparam logic [1:0] KIND_RD   = 2'd2;

	// queued command codes
	localparam logic [1:0] OP_ELEM = 2'd0;
	localparam logic [1:0] OP_WR   = 2'd1;
	localparam logic [1:0] OP_RD   = 2'd2;

	// register indexes
	localparam logic [1:0] REG_CLASS_COUNT   = 2'd0;
	localparam logic [1:0] REG_FEATURE_COUNT = 2'd1;
	localparam logic [1:0] REG_LEARNING_RATE = 2'd2;
	localparam logic [1:0] REG_TRAIN_ENABLE  = 2'd3;

	localparam int SCORE_W = 38;
	localparam int DEN_W   = 41;
	localparam logic [SCORE_W-1:0] ONE_Q24 = SCORE_W'(64'd16777216);

	typedef struct packed {
		logic [3:0]  class_count;
		logic [12:0] feature_count;
		logic [15:0] learning_rate;
		logic        train_enable;
	} cfg_t;

	typedef struct packed {
		logic [1:0]          op;
		logic                hit;
		logic                last;
		logic [11:0]         col;
		logic signed [15:0]  value;
		logic [2:0]          label;
		logic [2:0]          row;
		logic signed [31:0]  wval;
	} cmd_t;

	typedef struct packed {
		logic               valid;
		logic [2:0]         class_index;
		logic [15:0]        class_probability;
		logic [2:0]         predicted_class;
		logic               mispredicted;
		logic               buffer_overflow;
		logic signed [31:0] read_weight;
		logic               last_result;
	} res_t;

	// exp(n-8) in Q.24
	function automatic logic [35:0] exp_int(input logic [4:0] n);
		logic [35:0] v;
		case (n)
			5'd0:    v = 36'd5628;
			5'd1:    v = 36'd15299;
			5'd2:    v = 36'd41587;
			5'd3:    v = 36'd113044;
			5'd4:    v = 36'd307285;
			5'd5:    v = 36'd835288;
			5'd6:    v = 36'd2270549;
			5'd7:    v = 36'd6171993;
			5'd8:    v = 36'd16777216;
			5'd9:    v = 36'd45605201;
			5'd10:   v = 36'd123967790;
			5'd11:   v = 36'd336979392;
			5'd12:   v = 36'd916004956;
			5'd13:   v = 36'd2489959627;
			5'd14:   v = 36'd6768412009;
			5'd15:   v = 36'd18398451372;
			5'd16:   v = 36'd50012176036;
			default: v = 36'd0;
		endcase
		return v;
	endfunction

	// exp(k/16) in Q.16
	function automatic logic [17:0] exp_frac(input logic [4:0] k);
		logic [17:0] v;
		case (k)
			5'd0:    v = 18'd65536;
			5'd1:    v = 18'd69763;
			5'd2:    v = 18'd74262;
			5'd3:    v = 18'd79052;
			5'd4:    v = 18'd84150;
			5'd5:    v = 18'd89577;
			5'd6:    v = 18'd95354;
			5'd7:    v = 18'd101504;
			5'd8:    v = 18'd108051;
			5'd9:    v = 18'd115019;
			5'd10:   v = 18'd122437;
			5'd11:   v = 18'd130334;
			5'd12:   v = 18'd138740;
			5'd13:   v = 18'd147688;
			5'd14:   v = 18'd157213;
			5'd15:   v = 18'd167352;
			5'd16:   v = 18'd178145;
			default: v = 18'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/smr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module smr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/smr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smr_front
// Accepts input items, drops the ones that do nothing, turns the rest into
// commands and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module smr_front #(
	parameter int MAX_CLASSES  = smr_pkg::MAX_CLASSES_D,
	parameter int MAX_FEATURES = smr_pkg::MAX_FEATURES_D
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [11:0]        feature_index,
	input  logic signed [15:0] feature_value,
	input  logic               last_feature,
	input  logic [2:0]         sample_class,
	input  logic [2:0]         weight_class,
	input  logic signed [31:0] weight_value,
	input  logic [12:0]        feature_count,
	input  logic               clearing,
	input  logic               pop,
	output logic               head_valid,
	output smr_pkg::cmd_t      head
);
	import smr_pkg::*;

	localparam int QAW = $clog2(QUEUE_DEPTH);

	cmd_t           q_q [QUEUE_DEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QAW:0]   cnt_q;
	cmd_t           ent;
	logic           keep;
	logic           col_ok;
	logic           row_ok;
	logic           full;
	logic           push;

	always_comb begin
		col_ok = 32'(feature_index) < MAX_FEATURES;
		row_ok = 32'(weight_class) < MAX_CLASSES - 1;
		ent.op    = OP_ELEM;
		ent.hit   = 1'b0;
		ent.last  = last_feature;
		ent.col   = feature_index;
		ent.value = feature_value;
		ent.label = sample_class;
		ent.row   = weight_class;
		ent.wval  = weight_value;
		keep      = 1'b0;
		case (kind)
			KIND_ELEM: begin
				ent.op  = OP_ELEM;
				ent.hit = col_ok && (13'(feature_index) < feature_count);
				// an ignored element still ends the sample when marked last
				keep    = ent.hit || last_feature;
			end
			KIND_WR: begin
				ent.op  = OP_WR;
				ent.hit = col_ok && row_ok;
				keep    = ent.hit;
			end
			KIND_RD: begin
				ent.op  = OP_RD;
				ent.hit = col_ok && row_ok;
				keep    = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full       = cnt_q == (QAW+1)'(QUEUE_DEPTH);
	assign busy       = full || clearing;
	assign push       = start && !busy && keep;
	assign head_valid = cnt_q != '0;
	assign head       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/smr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smr_back
// Executes queued commands: dot product lanes, exp and divide sequencer,
// result emission, SGD replay over the sample buffer and weight access.
// ----------------------------------------------------------------------------
module smr_back #(
	parameter int MAX_CLASSES  = smr_pkg::MAX_CLASSES_D,
	parameter int MAX_FEATURES = smr_pkg::MAX_FEATURES_D,
	parameter int SAMPLE_DEPTH = smr_pkg::SAMPLE_DEPTH_D
) (
	input  logic          clk,
	input  logic          arst_n,
	input  smr_pkg::cfg_t cfg,
	input  logic          head_valid,
	input  smr_pkg::cmd_t head,
	output logic          pop,
	output logic          clearing,
	output smr_pkg::res_t res
);
	import smr_pkg::*;

	localparam int ROWS   = MAX_CLASSES - 1;
	localparam int FIDX_W = $clog2(MAX_FEATURES);
	localparam int BUF_AW = $clog2(SAMPLE_DEPTH);
	localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
	localparam int KW     = $clog2(MAX_CLASSES + 1);
	localparam int CIDX_W = $clog2(MAX_CLASSES);
	localparam int WW     = 32 * ROWS;
	localparam int BW     = FIDX_W + 16;
	localparam int REM_W  = DEN_W + 1;

	localparam logic [4:0] S_CLEAR  = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_EL_MUL = 5'd2;
	localparam logic [4:0] S_EL_ACC = 5'd3;
	localparam logic [4:0] S_WR_WB  = 5'd4;
	localparam logic [4:0] S_RD_OUT = 5'd5;
	localparam logic [4:0] S_FIN    = 5'd6;
	localparam logic [4:0] S_EXP0   = 5'd7;
	localparam logic [4:0] S_EXP1   = 5'd8;
	localparam logic [4:0] S_EXP2   = 5'd9;
	localparam logic [4:0] S_DIVI   = 5'd10;
	localparam logic [4:0] S_DIV    = 5'd11;
	localparam logic [4:0] S_EMIT   = 5'd12;
	localparam logic [4:0] S_GR     = 5'd13;
	localparam logic [4:0] S_UP_BUF = 5'd14;
	localparam logic [4:0] S_UP_WRD = 5'd15;
	localparam logic [4:0] S_UP_MUL = 5'd16;
	localparam logic [4:0] S_UP_WB  = 5'd17;
	localparam logic [4:0] S_DONE   = 5'd18;

	logic [4:0]               state_q;
	cmd_t                     cmd_q;
	logic [FIDX_W-1:0]        clr_q;
	logic signed [47:0]       sum_q   [ROWS];
	logic signed [47:0]       prod_q  [ROWS];
	logic signed [47:0]       acc_n   [ROWS];
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         e_q;
	logic                     ovf_q;
	logic [KW-1:0]            k_q;
	logic [2:0]               label_q;
	logic [CIDX_W-1:0]        i_q;
	logic [4:0]               n_s1;
	logic [3:0]               k_s1;
	logic [11:0]              r_s1;
	logic [4:0]               n_s2;
	logic [17:0]              g_s2;
	logic [SCORE_W-1:0]       score_q [MAX_CLASSES];
	logic [DEN_W-1:0]         den_q;
	logic [REM_W-1:0]         rem_q;
	logic [16:0]              quo_q;
	logic [4:0]               step_q;
	logic [15:0]              prob_q  [MAX_CLASSES];
	logic [15:0]              best_q;
	logic [CIDX_W-1:0]        pred_q;
	logic signed [34:0]       gr_q    [ROWS];
	logic [ROWS-1:0]          upd_q;
	logic signed [50:0]       v_q     [ROWS];
	logic signed [31:0]       w_s2    [ROWS];
	logic signed [15:0]       x_s1;
	logic [FIDX_W-1:0]        idx_s1;
	res_t                     res_q;
	res_t                     res_n;

	// weight and buffer memories
	logic                     w_we;
	logic [FIDX_W-1:0]        w_waddr;
	logic [WW-1:0]            w_wdata;
	logic [FIDX_W-1:0]        w_raddr;
	logic [WW-1:0]            w_rdata;
	logic                     b_we;
	logic [BW-1:0]            b_wdata;
	logic [BW-1:0]            b_rdata;

	// datapath temporaries
	logic signed [47:0]       s_sel;
	logic signed [32:0]       s_clamp;
	logic [20:0]              u_off;
	logic [17:0]              fa;
	logic [17:0]              fb;
	logic [25:0]              fprod;
	logic [53:0]              sprod;
	logic [SCORE_W-1:0]       num;
	logic [REM_W-1:0]         trial;
	logic                     take;
	logic [16:0]              quo_n;
	logic [15:0]              p_n;
	logic signed [31:0]       rw_sel;
	logic [WW-1:0]            upd_word;
	logic [KW-1:0]            k_cfg;
	logic [KW-1:0]            i_ext;
	logic                     elem_take;

	smr_ram #(.WIDTH(WW), .DEPTH(MAX_FEATURES)) u_wram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	smr_ram #(.WIDTH(BW), .DEPTH(SAMPLE_DEPTH)) u_bram (
		.clk   (clk),
		.we    (b_we),
		.waddr (cnt_q[BUF_AW-1:0]),
		.wdata (b_wdata),
		.raddr (e_q[BUF_AW-1:0]),
		.rdata (b_rdata)
	);

	assign clearing = state_q == S_CLEAR;
	assign pop      = (state_q == S_IDLE) && head_valid;
	assign res      = res_q;
	assign i_ext    = KW'(i_q);

	always_comb begin
		if (32'(cfg.class_count) < 2) begin
			k_cfg = KW'(2);
		end else if (32'(cfg.class_count) > MAX_CLASSES) begin
			k_cfg = KW'(MAX_CLASSES);
		end else begin
			k_cfg = KW'(cfg.class_count);
		end
	end

	assign elem_take = pop && head.op == OP_ELEM && head.hit;
	assign b_we      = elem_take && (cnt_q < CNT_W'(SAMPLE_DEPTH));
	assign b_wdata   = {FIDX_W'(head.col), head.value};
	assign w_raddr   = (state_q == S_UP_WRD) ? b_rdata[BW-1:16] : FIDX_W'(head.col);

	// saturating lane accumulate
	always_comb begin
		logic signed [48:0] t;
		for (int l = 0; l < ROWS; l++) begin
			t = 49'(sum_q[l]) + 49'(prod_q[l]);
			if (t[48] != t[47]) begin
				acc_n[l] = t[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
			end else begin
				acc_n[l] = t[47:0];
			end
		end
	end

	// dot clamp and offset for the exp table
	always_comb begin
		s_sel = sum_q[i_q];
		if (s_sel < -48'sd2147483648) begin
			s_clamp = {1'b1, 32'h8000_0000};
		end else if (s_sel > 48'sd2147483648) begin
			s_clamp = {1'b0, 32'h8000_0000};
		end else begin
			s_clamp = s_sel[32:0];
		end
		// floor shift by 12 is the upper bits
		u_off = s_clamp[32:12] + 21'd524288;
	end

	always_comb begin
		fa    = exp_frac({1'b0, k_s1});
		fb    = exp_frac({1'b0, k_s1} + 5'd1);
		fprod = (fb - fa) * r_s1;
		sprod = exp_int(n_s2) * g_s2;
	end

	// one restoring divide step
	always_comb begin
		num   = (i_ext == k_q - KW'(1)) ? ONE_Q24 : score_q[i_q];
		trial = (step_q == 5'd0) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
		take  = trial >= {1'b0, den_q};
		quo_n = {quo_q[15:0], take};
		p_n   = (quo_n > 17'd65535) ? 16'hFFFF : quo_n[15:0];
	end

	always_comb begin
		rw_sel = '0;
		for (int l = 0; l < ROWS; l++) begin
			if (32'(l) == 32'(cmd_q.row)) begin
				rw_sel = w_rdata[l*32 +: 32];
			end
		end
		if (!cmd_q.hit) begin
			rw_sel = '0;
		end
	end

	// weight update lanes
	always_comb begin
		logic [50:0]        av;
		logic [51:0]        rnd;
		logic signed [23:0] stp;
		logic signed [33:0] nw;
		for (int l = 0; l < ROWS; l++) begin
			av  = v_q[l][50] ? 51'(-v_q[l]) : 51'(v_q[l]);
			rnd = {1'b0, av} + 52'd134217728;
			stp = v_q[l][50] ? -$signed({1'b0, rnd[50:28]}) : $signed({1'b0, rnd[50:28]});
			nw  = 34'(w_s2[l]) - 34'(stp);
			if (!upd_q[l]) begin
				upd_word[l*32 +: 32] = w_s2[l];
			end else if (nw > 34'sd2147483647) begin
				upd_word[l*32 +: 32] = 32'h7FFF_FFFF;
			end else if (nw < -34'sd2147483648) begin
				upd_word[l*32 +: 32] = 32'h8000_0000;
			end else begin
				upd_word[l*32 +: 32] = nw[31:0];
			end
		end
	end

	always_comb begin
		w_we    = 1'b0;
		w_waddr = clr_q;
		w_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				w_we = 1'b1;
			end
			S_WR_WB: begin
				w_we    = 1'b1;
				w_waddr = FIDX_W'(cmd_q.col);
				w_wdata = w_rdata;
				for (int l = 0; l < ROWS; l++) begin
					if (32'(l) == 32'(cmd_q.row)) begin
						w_wdata[l*32 +: 32] = cmd_q.wval;
					end
				end
			end
			S_UP_WB: begin
				w_we    = 1'b1;
				w_waddr = idx_s1;
				w_wdata = upd_word;
			end
			default: begin
				w_we = 1'b0;
			end
		endcase
	end

	// result register input
	always_comb begin
		res_n = '0;
		case (state_q)
			S_RD_OUT: begin
				res_n.valid       = 1'b1;
				res_n.read_weight = rw_sel;
				res_n.last_result = 1'b1;
			end
			S_EMIT: begin
				res_n.valid             = 1'b1;
				res_n.class_index       = 3'(i_q);
				res_n.class_probability = prob_q[i_q];
				res_n.predicted_class   = 3'(pred_q);
				res_n.mispredicted      = 32'(pred_q) != 32'(label_q);
				res_n.buffer_overflow   = ovf_q;
				res_n.last_result       = i_ext == k_q - KW'(1);
			end
			default: begin
				res_n.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cmd_q   <= '0;
			clr_q   <= '0;
			cnt_q   <= '0;
			e_q     <= '0;
			ovf_q   <= 1'b0;
			k_q     <= KW'(2);
			label_q <= '0;
			i_q     <= '0;
			n_s1    <= '0;
			k_s1    <= '0;
			r_s1    <= '0;
			n_s2    <= '0;
			g_s2    <= '0;
			den_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			step_q  <= '0;
			best_q  <= '0;
			pred_q  <= '0;
			upd_q   <= '0;
			x_s1    <= '0;
			idx_s1  <= '0;
			for (int l = 0; l < ROWS; l++) begin
				sum_q[l]  <= '0;
				prod_q[l] <= '0;
				gr_q[l]   <= '0;
				v_q[l]    <= '0;
				w_s2[l]   <= '0;
			end
			for (int c = 0; c < MAX_CLASSES; c++) begin
				score_q[c] <= '0;
				prob_q[c]  <= '0;
			end
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == FIDX_W'(MAX_FEATURES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (head_valid) begin
						cmd_q <= head;
						case (head.op)
							OP_ELEM: begin
								if (head.hit) begin
									if (cnt_q < CNT_W'(SAMPLE_DEPTH)) begin
										cnt_q <= cnt_q + 1'b1;
									end else begin
										ovf_q <= 1'b1;
									end
									state_q <= S_EL_MUL;
								end else begin
									state_q <= S_FIN;
								end
							end
							OP_WR: begin
								state_q <= S_WR_WB;
							end
							OP_RD: begin
								state_q <= S_RD_OUT;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_EL_MUL: begin
					for (int l = 0; l < ROWS; l++) begin
						prod_q[l] <= $signed(w_rdata[l*32 +: 32]) * cmd_q.value;
					end
					state_q <= S_EL_ACC;
				end
				S_EL_ACC: begin
					for (int l = 0; l < ROWS; l++) begin
						sum_q[l] <= acc_n[l];
					end
					state_q <= cmd_q.last ? S_FIN : S_IDLE;
				end
				S_WR_WB: begin
					state_q <= S_IDLE;
				end
				S_RD_OUT: begin
					state_q <= S_IDLE;
				end
				S_FIN: begin
					k_q     <= k_cfg;
					label_q <= cmd_q.label;
					i_q     <= '0;
					den_q   <= DEN_W'(ONE_Q24);
					state_q <= S_EXP0;
				end
				S_EXP0: begin
					n_s1    <= u_off[20:16];
					k_s1    <= u_off[15:12];
					r_s1    <= u_off[11:0];
					state_q <= S_EXP1;
				end
				S_EXP1: begin
					n_s2    <= n_s1;
					g_s2    <= fa + 18'(fprod[25:12]);
					state_q <= S_EXP2;
				end
				S_EXP2: begin
					score_q[i_q] <= sprod[53:16];
					den_q        <= den_q + DEN_W'(sprod[53:16]);
					if (i_ext + KW'(1) == k_q - KW'(1)) begin
						i_q     <= '0;
						state_q <= S_DIVI;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_EXP0;
					end
				end
				S_DIVI: begin
					rem_q   <= REM_W'(num);
					quo_q   <= '0;
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q  <= take ? trial - {1'b0, den_q} : trial;
					quo_q  <= quo_n;
					step_q <= step_q + 5'd1;
					if (step_q == 5'd16) begin
						prob_q[i_q] <= p_n;
						if (i_q == '0 || p_n > best_q) begin
							best_q <= p_n;
							pred_q <= i_q;
						end
						if (i_ext == k_q - KW'(1)) begin
							i_q     <= '0;
							state_q <= S_EMIT;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_DIVI;
						end
					end
				end
				S_EMIT: begin
					if (i_ext == k_q - KW'(1)) begin
						state_q <= cfg.train_enable ? S_GR : S_DONE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_GR: begin
					for (int l = 0; l < ROWS; l++) begin
						gr_q[l] <= ($signed({2'b00, prob_q[l]})
							- ((32'(l) == 32'(label_q)) ? 18'sd65536 : 18'sd0))
							* $signed({1'b0, cfg.learning_rate});
						upd_q[l] <= 32'(l) < 32'(k_q) - 1;
					end
					e_q     <= '0;
					state_q <= (cnt_q == '0) ? S_DONE : S_UP_BUF;
				end
				S_UP_BUF: begin
					state_q <= S_UP_WRD;
				end
				S_UP_WRD: begin
					x_s1    <= b_rdata[15:0];
					idx_s1  <= b_rdata[BW-1:16];
					state_q <= S_UP_MUL;
				end
				S_UP_MUL: begin
					for (int l = 0; l < ROWS; l++) begin
						v_q[l]  <= gr_q[l] * x_s1;
						w_s2[l] <= w_rdata[l*32 +: 32];
					end
					state_q <= S_UP_WB;
				end
				S_UP_WB: begin
					e_q     <= e_q + 1'b1;
					state_q <= (e_q + 1'b1 == cnt_q) ? S_DONE : S_UP_BUF;
				end
				S_DONE: begin
					for (int l = 0; l < ROWS; l++) begin
						sum_q[l] <= '0;
					end
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |=> !res_q.valid)
		else $error("result during weight clear");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(SAMPLE_DEPTH))
		else $error("buffer count past depth");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.valid && res_q.last_result |=> !res_q.valid)
		else $error("result right after a final result");

	a_den_floor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> den_q >= DEN_W'(ONE_Q24))
		else $error("denominator below reference score");

endmodule

// ===== sv/softmax_regression_sgd_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_regression_sgd_engine
// Multinomial logistic regression over sparse samples with per-sample SGD.
// ----------------------------------------------------------------------------
// channel   | handshake                           | payload
// ----------+-------------------------------------+-----------------------------
// item in   | start, busy (accept: start & !busy) | kind .. weight_value
// result    | result_valid, one cycle per result  | class_index .. last_result
// config    | psel, penable, pwrite, pready       | paddr, pwdata, prdata
//
// feature element: a wide weight row read, lane multiply and saturating add
// in the back end; weight write and weight read both read the row first, a
// read's result is registered onto the ports. sample end: a setup step, an exp
// step per class but the last, a restoring divide per class, one result per
// class and a cleanup step; with training a gradient step and a replay of
// each buffered element through the weight port precede the cleanup step.
// after reset a clearing pass over all MAX_FEATURES rows zeroes the weights,
// busy stays high meanwhile; register writes are taken at any time.
// a four entry queue lets items be taken while the back end works; after the
// clearing pass busy is high only when it is full. results cannot be held off.
module softmax_regression_sgd_engine
#(
	parameter int MAX_CLASSES  = smr_pkg::MAX_CLASSES_D,
	parameter int MAX_FEATURES = smr_pkg::MAX_FEATURES_D,
	parameter int SAMPLE_DEPTH = smr_pkg::SAMPLE_DEPTH_D
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [11:0]        feature_index,
	input  logic signed [15:0] feature_value,
	input  logic               last_feature,
	input  logic [2:0]         sample_class,
	input  logic [2:0]         weight_class,
	input  logic signed [31:0] weight_value,
	output logic               result_valid,
	output logic [2:0]         class_index,
	output logic [15:0]        class_probability,
	output logic [2:0]         predicted_class,
	output logic               mispredicted,
	output logic               buffer_overflow,
	output logic signed [31:0] read_weight,
	output logic               last_result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import smr_pkg::*;

	cfg_t cfg_q;
	logic clearing;
	logic pop;
	logic head_valid;
	cmd_t head;
	res_t res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.class_count   <= 4'd2;
			cfg_q.feature_count <= 13'd4096;
			cfg_q.learning_rate <= 16'd3277;
			cfg_q.train_enable  <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_CLASS_COUNT:   cfg_q.class_count   <= pwdata[3:0];
				REG_FEATURE_COUNT: cfg_q.feature_count <= pwdata[12:0];
				REG_LEARNING_RATE: cfg_q.learning_rate <= pwdata[15:0];
				REG_TRAIN_ENABLE:  cfg_q.train_enable  <= pwdata[0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_CLASS_COUNT:   prdata = 32'(cfg_q.class_count);
			REG_FEATURE_COUNT: prdata = 32'(cfg_q.feature_count);
			REG_LEARNING_RATE: prdata = 32'(cfg_q.learning_rate);
			REG_TRAIN_ENABLE:  prdata = 32'(cfg_q.train_enable);
			default:           prdata = '0;
		endcase
	end

	smr_front #(
		.MAX_CLASSES  (MAX_CLASSES),
		.MAX_FEATURES (MAX_FEATURES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.feature_index (feature_index),
		.feature_value (feature_value),
		.last_feature  (last_feature),
		.sample_class  (sample_class),
		.weight_class  (weight_class),
		.weight_value  (weight_value),
		.feature_count (cfg_q.feature_count),
		.clearing      (clearing),
		.pop           (pop),
		.head_valid    (head_valid),
		.head          (head)
	);

	smr_back #(
		.MAX_CLASSES  (MAX_CLASSES),
		.MAX_FEATURES (MAX_FEATURES),
		.SAMPLE_DEPTH (SAMPLE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.res        (res)
	);

	assign result_valid      = res.valid;
	assign class_index       = res.class_index;
	assign class_probability = res.class_probability;
	assign predicted_class   = res.predicted_class;
	assign mispredicted      = res.mispredicted;
	assign buffer_overflow   = res.buffer_overflow;
	assign read_weight       = res.read_weight;
	assign last_result       = res.last_result;

endmodule
